// File: sv/sine_polynomial_approx_top_defines.svh
// assertion macros for the sine approximation rtl
`ifndef SINE_POLYNOMIAL_APPROX_TOP_DEFINES_SVH
`define SINE_POLYNOMIAL_APPROX_TOP_DEFINES_SVH

// checked outside reset
`define SPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset too
`define SPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/spa_pkg.sv
// types and constants for the sine approximation block
package spa_pkg;

  localparam int JW = 20;
  localparam int QDEPTH = 4;
  localparam int QAW = 2;
  localparam int QCW = 3;

  localparam logic [30:0] FOPI_Q30 = 31'd1367130551;
  // dp1+dp2+dp3 in q40, split for two narrow multipliers
  localparam logic [39:0] DP_Q40 = 40'd863554413089;
  localparam logic [19:0] DP_HI = DP_Q40[39:20];
  localparam logic [19:0] DP_LO = DP_Q40[19:0];

  localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
  localparam logic signed [31:0] SIN_P0 = -32'sd209544;
  localparam logic signed [31:0] SIN_P1 = 32'sd8946590;
  localparam logic signed [31:0] SIN_P2 = -32'sd178956841;
  localparam logic signed [31:0] COS_P0 = 32'sd26235;
  localparam logic signed [31:0] COS_P1 = -32'sd1491139;
  localparam logic signed [31:0] COS_P2 = 32'sd44739220;

  typedef struct packed {
    logic [JW-1:0] j;
    logic [31:0]   mag;
    logic          neg;
  } oct_word_t;

endpackage

// File: sv/spa_front.sv
// front end: magnitude, sign and even octant index
module spa_front #(
  parameter int ANGLE_FRAC_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  logic signed [31:0]       angle,
  output logic                     push,
  output spa_pkg::oct_word_t       word
);
  import spa_pkg::*;

  logic        v1;
  logic [31:0] mag1;
  logic        neg1;
  logic [62:0] prod1;
  logic [31:0] mag_c;
  logic [62:0] jfull;
  logic [JW-1:0] jt;
  logic [JW-1:0] je;

  // most negative angle gives 2^31, exact in 32 unsigned bits
  assign mag_c = angle[31] ? (~angle + 32'd1) : angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= take;
    end
    mag1  <= mag_c;
    neg1  <= angle[31];
    prod1 <= 63'(mag_c) * 63'(FOPI_Q30);
  end

  assign jfull = prod1 >> (ANGLE_FRAC_BITS + 30);
  assign jt = jfull[JW-1:0];
  assign je = (jt + JW'(1)) & ~JW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= v1;
    end
    word.j   <= je;
    word.mag <= mag1;
    word.neg <= neg1;
  end
endmodule

// File: sv/spa_queue.sv
// short queue between front end and polynomial back end
`include "sine_polynomial_approx_top_defines.svh"
module spa_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  spa_pkg::oct_word_t wr_word,
  output logic               rd_valid,
  output spa_pkg::oct_word_t rd_word,
  output logic               almost_full
);
  import spa_pkg::*;

  oct_word_t       mem [QDEPTH];
  logic [QAW-1:0]  wptr;
  logic [QAW-1:0]  rptr;
  logic [QCW-1:0]  count;
  logic            pop;

  assign pop = (count != '0);
  // two words may still be in flight in the front end
  assign almost_full = (count >= QCW'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr_word;
    end
    if (pop) begin
      rd_word <= mem[rptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr     <= '0;
      rptr     <= '0;
      count    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= pop;
      if (push) begin
        wptr <= wptr + QAW'(1);
      end
      if (pop) begin
        rptr <= rptr + QAW'(1);
      end
      count <= count + QCW'(push) - QCW'(pop);
    end
  end

  `SPA_ASSERT(a_no_overflow, !(push && !pop && count == QCW'(QDEPTH)), "queue overflow")
  `SPA_ASSERT(a_count_range, count <= QCW'(QDEPTH), "queue count out of range")
  `SPA_ASSERT(a_ptr_track, (count == '0 || count == QCW'(QDEPTH)) |-> wptr == rptr,
              "queue pointers disagree with count")
endmodule

// File: sv/spa_back.sv
// back end: range reduction, polynomial, sign and saturation
module spa_back #(
  parameter int ANGLE_FRAC_BITS  = 24,
  parameter int RESULT_FRAC_BITS = 30
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  spa_pkg::oct_word_t in_word,
  output logic               done,
  output logic signed [31:0] sine
);
  import spa_pkg::*;

  localparam int NST = 7;

  logic [NST-1:0] vld;
  logic [NST-1:0] cosq;
  logic [NST-1:0] flip;

  // stage 1
  logic [39:0]        p_hi;
  logic [39:0]        p_lo;
  logic [63:0]        magsh;
  // stage 2
  logic signed [63:0] r_c;
  logic signed [63:0] r_sh;
  logic signed [31:0] x2;
  // stage 3..7
  logic signed [31:0] x3, x4, x5, x6;
  logic signed [31:0] z3, z4, z5, z6;
  logic signed [31:0] y4, y5, y6;
  logic signed [33:0] y7;
  logic signed [63:0] pz, p4, p5, p6, p7;
  logic signed [31:0] c0, c1, c2;
  logic signed [31:0] m6;
  logic signed [33:0] v_c;
  logic signed [33:0] vs_c;
  logic signed [33:0] vq_c;
  logic signed [33:0] lim;

  assign r_c  = $signed(magsh) - $signed({4'd0, p_hi, 20'd0}) - $signed({24'd0, p_lo});
  assign r_sh = r_c >>> 10;
  assign pz   = x2 * x2;
  assign c0 = cosq[2] ? COS_P0 : SIN_P0;
  assign c1 = cosq[2] ? COS_P1 : SIN_P1;
  assign c2 = cosq[3] ? COS_P2 : SIN_P2;
  assign p4 = 64'(c0) * 64'(z3);
  assign p5 = 64'(y4) * 64'(z4);
  assign p6 = 64'(y5) * 64'(z5);
  assign m6 = cosq[5] ? z6 : x6;
  assign p7 = 64'(y6) * 64'(m6);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NST-2:0], in_valid};
    end
    cosq <= {cosq[NST-2:0], in_word.j[1]};
    flip <= {flip[NST-2:0], in_word.j[2] ^ in_word.neg};

    p_hi  <= 40'(in_word.j) * 40'(DP_HI);
    p_lo  <= 40'(in_word.j) * 40'(DP_LO);
    magsh <= 64'(in_word.mag) << (40 - ANGLE_FRAC_BITS);

    x2 <= r_sh[31:0];

    z3 <= pz[61:30];
    x3 <= x2;

    y4 <= 32'(p4 >>> 30) + c1;
    z4 <= z3;
    x4 <= x3;

    y5 <= 32'(p5 >>> 30) + c2;
    z5 <= z4;
    x5 <= x4;

    y6 <= 32'(p6 >>> 30);
    z6 <= z5;
    x6 <= x5;

    // cosine adds 1 - z/2, sine adds x
    if (cosq[5]) begin
      y7 <= 34'(p7 >>> 30) - 34'(z6 >>> 1) + ONE_Q30;
    end else begin
      y7 <= 34'(p7 >>> 30) + 34'(x6);
    end
  end

  assign v_c  = flip[6] ? -y7 : y7;
  assign vs_c = v_c >>> (30 - RESULT_FRAC_BITS);
  assign lim  = 34'sd1 <<< RESULT_FRAC_BITS;

  always_comb begin
    priority if (vs_c > lim) begin
      vq_c = lim;
    end else if (vs_c < -lim) begin
      vq_c = -lim;
    end else begin
      vq_c = vs_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[NST-1];
    end
    sine <= vq_c[31:0];
  end
endmodule

// File: sv/sine_polynomial_approx_top.sv
// Sine of a signed Q8.24 radian angle, returned as Q2.30 and saturated to
// plus or minus one. A word is taken on any cycle with start high and busy
// low; busy stays low in normal use, so one angle can enter every clock.
// Each result appears on sine for one cycle with done high. On the way, two
// front-end registers form the magnitude and the even octant index through a
// 32x31 multiplier, the queue's memory and read register pass the word on,
// seven back-end stages carry range reduction, squaring and the four
// multiplies of the selected polynomial, and the output register applies
// sign and saturation. Results come out in input order and cannot be held
// off.
module sine_polynomial_approx_top #(
  parameter int ANGLE_FRAC_BITS  = 24,
  parameter int RESULT_FRAC_BITS = 30
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] angle,
  output logic               done,
  output logic signed [31:0] sine
);
  import spa_pkg::*;

  logic      take;
  logic      push;
  oct_word_t f_word;
  logic      q_valid;
  oct_word_t q_word;

  assign take = start & ~busy;

  spa_front #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .take(take), .angle(angle), .push(push), .word(f_word)
  );

  spa_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wr_word(f_word),
    .rd_valid(q_valid), .rd_word(q_word), .almost_full(busy)
  );

  spa_back #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
  ) u_back (
    .clk(clk), .rst(rst), .in_valid(q_valid), .in_word(q_word),
    .done(done), .sine(sine)
  );
endmodule

// File: tb/sine_checker.sv
// checker that predicts and compares the sine results of the block
module sine_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] angle,
  input  logic               done,
  input  logic signed [31:0] sine,
  output int                 errors,
  output int                 pending
);
  localparam logic signed [63:0] DP1 = 64'sd863288426496;
  localparam logic signed [63:0] DP2 = 64'sd265945088;
  localparam logic signed [63:0] DP3 = 64'sd41505;
  localparam logic signed [63:0] S0 = -64'sd209544;
  localparam logic signed [63:0] S1 = 64'sd8946590;
  localparam logic signed [63:0] S2 = -64'sd178956841;
  localparam logic signed [63:0] C0 = 64'sd26235;
  localparam logic signed [63:0] C1 = -64'sd1491139;
  localparam logic signed [63:0] C2 = 64'sd44739220;
  localparam logic signed [63:0] ONE = 64'sd1073741824;

  logic signed [31:0] sines_due[$];

  // arithmetic shift is floor division for signed values
  function automatic logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p >>> 30;
  endfunction

  function automatic logic signed [31:0] sine_of(logic [31:0] a);
    logic               neg;
    logic [63:0]        mag;
    logic [63:0]        oct;
    logic signed [63:0] r, x, z, y, v;
    neg = a[31];
    mag = neg ? {32'd0, -a} : {32'd0, a};
    if (neg && a == 32'h8000_0000) mag = 64'h8000_0000;
    oct = (mag * 64'd1367130551) >> 54;
    oct = (oct + 1) & ~64'd1;
    r = $signed(mag << 16);
    r = r - $signed(oct) * DP1 - $signed(oct) * DP2 - $signed(oct) * DP3;
    x = r >>> 10;
    z = qmul(x, x);
    if (oct[1]) begin
      y = qmul(C0, z) + C1;
      y = qmul(y, z) + C2;
      y = qmul(qmul(y, z), z);
      v = y - (z >>> 1) + ONE;
    end else begin
      y = qmul(S0, z) + S1;
      y = qmul(y, z) + S2;
      y = qmul(qmul(y, z), x);
      v = y + x;
    end
    if (oct[2] != neg) v = -v;
    if (v > ONE) v = ONE;
    if (v < -ONE) v = -ONE;
    return v[31:0];
  endfunction

  task automatic report(string what, logic signed [31:0] got, logic signed [31:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  initial errors = 0;
  assign pending = sines_due.size();

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (sines_due.size() == 0) report("unexpected word", sine, 0);
        else begin
          if (sine !== sines_due[0]) report("sine", sine, sines_due[0]);
          void'(sines_due.pop_front());
        end
      end
      if (start && !busy) sines_due.push_back(sine_of(angle));
    end
  end
endmodule

// File: tb/tb.sv
// stimulus and verdict for the sine approximation block
module tb;
  logic               clk = 0;
  logic               rst = 1;
  logic               start = 0;
  logic signed [31:0] angle = 0;
  logic               busy, done;
  logic signed [31:0] sine;
  int                 errors, pending;
  int                 cycles = 0;

  always #4 clk = ~clk;

  sine_polynomial_approx_top dut (.*);
  sine_checker chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > 200000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send(logic [31:0] a, int gap);
    start <= 1;
    angle <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  logic [31:0] directed[] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h8000_0001, 32'h0192_1FB5, 32'hFE6D_E04B, 32'h0324_3F6A, 32'h0648_7ED5,
    32'h04B6_5F1F, 32'h00C9_0FDB, 32'h00C9_0FDA, 32'h012D_97C8, 32'h02BC_03C5,
    32'hFCDB_C096, 32'h0100_0000, 32'hFF00_0000, 32'h0AAA_AAAA, 32'h5555_5555};

  initial begin
    logic [31:0] a;
    repeat (3) @(posedge clk);
    rst <= 0;
    foreach (directed[i]) send(directed[i], $urandom_range(0, 2));
    for (int i = 0; i < 1400; i++) begin
      case ($urandom_range(0, 3))
        0: a = $urandom();
        1: a = $signed($urandom_range(0, 32'h0C00_0000)) * ($urandom_range(0, 1) ? 1 : -1);
        2: a = 32'h00C9_0FDB * $urandom_range(0, 40) + $urandom_range(0, 15) - 8;
        default: a = $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
      endcase
      // bursts with no gap, otherwise a random wait
      send(a, (i % 200 < 50) ? 0 : $urandom_range(0, 9));
      if (i == 700) begin
        start <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
